[design/crbe_pkg.sv]
package crbe_pkg;

    localparam int unsigned MAX_DIM     = 4096;
    localparam int unsigned QUEUE_DEPTH = 4;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 15;
    localparam int unsigned OFS_W      = 26;
    localparam int unsigned DIM_W      = 13;
    localparam int unsigned PITCH_W    = 15;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_PITCH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DST_PITCH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 3'd5;

    localparam logic [DIM_W-1:0]   RST_WIDTH  = 13'd640;
    localparam logic [DIM_W-1:0]   RST_HEIGHT = 13'd480;
    localparam logic [PITCH_W-1:0] RST_PITCH  = 15'd2560;

    localparam logic OP_START = 1'b0;
    localparam logic OP_PIXEL = 1'b1;

    localparam logic [1:0] MODE_DIRECT = 2'd0;
    localparam logic [1:0] MODE_THRESH = 2'd1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_MODE  = 2'd2;
    localparam logic [1:0] ST_IDLE  = 2'd3;

    typedef struct packed {
        logic [DIM_W-1:0]   src_width;
        logic [PITCH_W-1:0] src_pitch;
        logic [DIM_W-1:0]   src_height;
        logic [DIM_W-1:0]   dst_width;
        logic [PITCH_W-1:0] dst_pitch;
        logic [DIM_W-1:0]   dst_height;
    } cfg_t;

    // classified request handed from front to back
    typedef struct packed {
        logic               is_pixel;
        logic [1:0]         status;
        logic               mode;
        logic [DIM_W-1:0]   clip_w;
        logic [DIM_W-1:0]   clip_h;
        logic [OFS_W-1:0]   src_ofs;
        logic [OFS_W-1:0]   dst_ofs;
        logic [31:0]        pixel;
    } job_t;

endpackage

[design/crbe_front.sv]
module crbe_front (
    input  logic                clk,
    input  logic                rst_n,
    input  crbe_pkg::cfg_t      cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                opcode,
    input  logic signed [12:0]  src_x,
    input  logic signed [12:0]  src_y,
    input  logic signed [12:0]  dst_x,
    input  logic signed [12:0]  dst_y,
    input  logic [12:0]         rect_width,
    input  logic [12:0]         rect_height,
    input  logic [1:0]          blend_mode,
    input  logic [31:0]         src_pixel,
    output logic                push_valid,
    input  logic                push_ready,
    output crbe_pkg::job_t      push_job
);

    localparam logic signed [15:0] MaxDim = 16'(crbe_pkg::MAX_DIM);

    // stage 1: saturation and top-left clip
    logic               s1_valid_reg;
    logic               s1_pixel_op_reg;
    logic [1:0]         s1_mode_reg;
    logic signed [15:0] s1_sx_reg, s1_sy_reg, s1_dx_reg, s1_dy_reg, s1_bw_reg, s1_bh_reg;
    logic [31:0]        s1_pix_reg;
    logic signed [15:0] s1_sx_next, s1_sy_next, s1_dx_next, s1_dy_next;
    logic signed [15:0] s1_bw_next, s1_bh_next;

    // stage 2: bottom-right clip and classification
    logic               s2_valid_reg;
    logic               s2_pixel_op_reg;
    logic [1:0]         s2_status_reg;
    logic               s2_mode_reg;
    logic [12:0]        s2_sx_reg, s2_sy_reg, s2_dx_reg, s2_dy_reg, s2_bw_reg, s2_bh_reg;
    logic [31:0]        s2_pix_reg;
    logic signed [15:0] s2_bw_next, s2_bh_next;
    logic [1:0]         s2_status_next;

    // stage 3: row offsets
    logic               s3_valid_reg;
    logic               s3_pixel_op_reg;
    logic [1:0]         s3_status_reg;
    logic               s3_mode_reg;
    logic [27:0]        s3_src_prod_reg, s3_dst_prod_reg;
    logic [12:0]        s3_sx_reg, s3_dx_reg, s3_bw_reg, s3_bh_reg;
    logic [31:0]        s3_pix_reg;

    logic s1_ready, s2_ready, s3_ready;

    assign s3_ready = !s3_valid_reg || push_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    always_comb
    begin
        s1_sx_next = {{3{src_x[12]}}, src_x};
        s1_sy_next = {{3{src_y[12]}}, src_y};
        s1_dx_next = {{3{dst_x[12]}}, dst_x};
        s1_dy_next = {{3{dst_y[12]}}, dst_y};
        s1_bw_next = {3'b000, rect_width};
        s1_bh_next = {3'b000, rect_height};
        if (s1_bw_next > MaxDim)
            s1_bw_next = MaxDim;
        if (s1_bh_next > MaxDim)
            s1_bh_next = MaxDim;
        if (s1_sx_next < 0)
        begin
            s1_bw_next = s1_bw_next + s1_sx_next;
            s1_dx_next = s1_dx_next - s1_sx_next;
            s1_sx_next = '0;
        end
        if (s1_sy_next < 0)
        begin
            s1_bh_next = s1_bh_next + s1_sy_next;
            s1_dy_next = s1_dy_next - s1_sy_next;
            s1_sy_next = '0;
        end
        if (s1_dx_next < 0)
        begin
            s1_bw_next = s1_bw_next + s1_dx_next;
            s1_sx_next = s1_sx_next - s1_dx_next;
            s1_dx_next = '0;
        end
        if (s1_dy_next < 0)
        begin
            s1_bh_next = s1_bh_next + s1_dy_next;
            s1_sy_next = s1_sy_next - s1_dy_next;
            s1_dy_next = '0;
        end
    end

    always_comb
    begin
        logic signed [15:0] sw, sh, dw, dh;
        sw = {3'b000, cfg.src_width};
        sh = {3'b000, cfg.src_height};
        dw = {3'b000, cfg.dst_width};
        dh = {3'b000, cfg.dst_height};
        s2_bw_next = s1_bw_reg;
        s2_bh_next = s1_bh_reg;
        if (s1_sx_reg + s2_bw_next - sw > 0)
            s2_bw_next = sw - s1_sx_reg;
        if (s1_sy_reg + s2_bh_next - sh > 0)
            s2_bh_next = sh - s1_sy_reg;
        if (s1_dx_reg + s2_bw_next - dw > 0)
            s2_bw_next = dw - s1_dx_reg;
        if (s1_dy_reg + s2_bh_next - dh > 0)
            s2_bh_next = dh - s1_dy_reg;
        // empty wins over a bad mode
        if (s2_bw_next <= 0 || s2_bh_next <= 0)
            s2_status_next = crbe_pkg::ST_EMPTY;
        else if (s1_mode_reg != crbe_pkg::MODE_DIRECT && s1_mode_reg != crbe_pkg::MODE_THRESH)
            s2_status_next = crbe_pkg::ST_MODE;
        else
            s2_status_next = crbe_pkg::ST_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= in_valid;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
            if (s3_ready)
                s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && s1_ready)
        begin
            s1_pixel_op_reg <= (opcode == crbe_pkg::OP_PIXEL);
            s1_mode_reg     <= blend_mode;
            s1_sx_reg       <= s1_sx_next;
            s1_sy_reg       <= s1_sy_next;
            s1_dx_reg       <= s1_dx_next;
            s1_dy_reg       <= s1_dy_next;
            s1_bw_reg       <= s1_bw_next;
            s1_bh_reg       <= s1_bh_next;
            s1_pix_reg      <= src_pixel;
        end
        if (s1_valid_reg && s2_ready)
        begin
            s2_pixel_op_reg <= s1_pixel_op_reg;
            s2_status_reg   <= s2_status_next;
            s2_mode_reg     <= s1_mode_reg[0];
            s2_sx_reg       <= s1_sx_reg[12:0];
            s2_sy_reg       <= s1_sy_reg[12:0];
            s2_dx_reg       <= s1_dx_reg[12:0];
            s2_dy_reg       <= s1_dy_reg[12:0];
            s2_bw_reg       <= s2_bw_next[12:0];
            s2_bh_reg       <= s2_bh_next[12:0];
            s2_pix_reg      <= s1_pix_reg;
        end
        if (s2_valid_reg && s3_ready)
        begin
            s3_pixel_op_reg <= s2_pixel_op_reg;
            s3_status_reg   <= s2_status_reg;
            s3_mode_reg     <= s2_mode_reg;
            s3_src_prod_reg <= s2_sy_reg * cfg.src_pitch;
            s3_dst_prod_reg <= s2_dy_reg * cfg.dst_pitch;
            s3_sx_reg       <= s2_sx_reg;
            s3_dx_reg       <= s2_dx_reg;
            s3_bw_reg       <= s2_bw_reg;
            s3_bh_reg       <= s2_bh_reg;
            s3_pix_reg      <= s2_pix_reg;
        end
    end

    assign push_valid        = s3_valid_reg;
    assign push_job.is_pixel = s3_pixel_op_reg;
    assign push_job.status   = s3_status_reg;
    assign push_job.mode     = s3_mode_reg;
    assign push_job.clip_w   = s3_bw_reg;
    assign push_job.clip_h   = s3_bh_reg;
    assign push_job.src_ofs  = s3_src_prod_reg[25:0] + {11'd0, s3_sx_reg, 2'b00};
    assign push_job.dst_ofs  = s3_dst_prod_reg[25:0] + {11'd0, s3_dx_reg, 2'b00};
    assign push_job.pixel    = s3_pix_reg;

endmodule

[design/crbe_queue.sv]
module crbe_queue #(
    parameter int unsigned DEPTH = crbe_pkg::QUEUE_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  crbe_pkg::job_t  wdata,
    output logic            full,
    input  logic            pop,
    output crbe_pkg::job_t  rdata,
    output logic            empty
);

    localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

    crbe_pkg::job_t  slot_reg [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CntW-1:0] count_reg;

    assign full  = (count_reg == FullCnt);
    assign empty = (count_reg == '0);
    assign rdata = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= wdata;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FullCnt)
        else $error("queue count beyond depth");

    a_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (full && !pop) |-> !push)
        else $error("queue written while full");

endmodule

[design/crbe_back.sv]
module crbe_back (
    input  logic            clk,
    input  logic            rst_n,
    input  crbe_pkg::cfg_t  cfg,
    input  logic            job_valid,
    input  crbe_pkg::job_t  job,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [1:0]      status,
    output logic [25:0]     fetch_offset,
    output logic [25:0]     store_offset,
    output logic            write_enable,
    output logic [31:0]     write_data,
    output logic            last
);

    logic        busy_reg, busy_next;
    logic        mode_reg, mode_next;
    logic [12:0] clip_w_reg, clip_w_next, clip_h_reg, clip_h_next;
    logic [12:0] col_reg, col_next, row_reg, row_next;
    logic [25:0] src_row_reg, src_row_next, dst_row_reg, dst_row_next;
    logic [25:0] src_cur_reg, src_cur_next, dst_cur_reg, dst_cur_next;

    logic        out_valid_reg;
    logic [1:0]  status_reg, status_next;
    logic [25:0] fetch_reg, fetch_next, store_reg, store_next;
    logic        we_reg, we_next;
    logic [31:0] data_reg, data_next;
    logic        last_reg, last_next;

    assign pop = job_valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        busy_next    = busy_reg;
        mode_next    = mode_reg;
        clip_w_next  = clip_w_reg;
        clip_h_next  = clip_h_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        src_row_next = src_row_reg;
        dst_row_next = dst_row_reg;
        src_cur_next = src_cur_reg;
        dst_cur_next = dst_cur_reg;
        status_next  = crbe_pkg::ST_OK;
        fetch_next   = '0;
        store_next   = '0;
        we_next      = 1'b0;
        data_next    = '0;
        last_next    = 1'b0;
        if (job.is_pixel)
        begin
            if (!busy_reg)
                status_next = crbe_pkg::ST_IDLE;
            else
            begin
                we_next    = !mode_reg || job.pixel[31];
                data_next  = job.pixel;
                store_next = dst_cur_reg;
                col_next   = col_reg + 1'b1;
                if (col_next >= clip_w_reg)
                begin
                    col_next     = '0;
                    row_next     = row_reg + 1'b1;
                    src_row_next = src_row_reg + {11'd0, cfg.src_pitch};
                    dst_row_next = dst_row_reg + {11'd0, cfg.dst_pitch};
                    src_cur_next = src_row_next;
                    dst_cur_next = dst_row_next;
                    last_next    = (row_next >= clip_h_reg);
                end
                else
                begin
                    src_cur_next = src_cur_reg + 26'd4;
                    dst_cur_next = dst_cur_reg + 26'd4;
                end
                fetch_next = last_next ? '0 : src_cur_next;
                busy_next  = !last_next;
            end
        end
        else
        begin
            // a new start always drops whatever was running
            busy_next   = 1'b0;
            status_next = job.status;
            if (job.status == crbe_pkg::ST_OK)
            begin
                busy_next    = 1'b1;
                mode_next    = job.mode;
                clip_w_next  = job.clip_w;
                clip_h_next  = job.clip_h;
                col_next     = '0;
                row_next     = '0;
                src_row_next = job.src_ofs;
                dst_row_next = job.dst_ofs;
                src_cur_next = job.src_ofs;
                dst_cur_next = job.dst_ofs;
                fetch_next   = job.src_ofs;
                store_next   = job.dst_ofs;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            mode_reg      <= 1'b0;
            clip_w_reg    <= '0;
            clip_h_reg    <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            src_row_reg   <= '0;
            dst_row_reg   <= '0;
            src_cur_reg   <= '0;
            dst_cur_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                busy_reg    <= busy_next;
                mode_reg    <= mode_next;
                clip_w_reg  <= clip_w_next;
                clip_h_reg  <= clip_h_next;
                col_reg     <= col_next;
                row_reg     <= row_next;
                src_row_reg <= src_row_next;
                dst_row_reg <= dst_row_next;
                src_cur_reg <= src_cur_next;
                dst_cur_reg <= dst_cur_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            status_reg <= status_next;
            fetch_reg  <= fetch_next;
            store_reg  <= store_next;
            we_reg     <= we_next;
            data_reg   <= data_next;
            last_reg   <= last_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign fetch_offset = fetch_reg;
    assign store_offset = store_reg;
    assign write_enable = we_reg;
    assign write_data   = data_reg;
    assign last         = last_reg;

    a_last_ends_blit: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && last_next) |=> !busy_reg)
        else $error("blit still running after its final pixel");

    a_last_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && last_reg) |-> (status_reg == crbe_pkg::ST_OK && fetch_reg == '0))
        else $error("final pixel with bad status or fetch offset");

    a_error_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg != crbe_pkg::ST_OK) |-> (!we_reg && !last_reg))
        else $error("error result carries a write");

endmodule

[design/clipped_rect_blit_engine.sv]
// Clipped 32bpp rectangle blitter. A start request (opcode 0) is clipped against
// both surfaces and answered with the first source and destination byte offsets,
// or with an empty or bad-mode status; each pixel request (opcode 1) brings one
// fetched source pixel and is answered with its store offset, write enable, data,
// the next fetch offset and a last flag, or with an idle status when no blit runs.
// One request is accepted and one result leaves per cycle while the queue has
// room and the receiver is ready. A request passes three front stages (top-left
// clip, bottom-right clip, row offset multiply), a small queue and the output
// register of the pixel walker, whose counter and offset update bounds the rate.
module clipped_rect_blit_engine #(
    parameter int unsigned QUEUE_DEPTH = crbe_pkg::QUEUE_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic [2:0]          cfg_index,
    input  logic [14:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                opcode,
    input  logic signed [12:0]  src_x,
    input  logic signed [12:0]  src_y,
    input  logic signed [12:0]  dst_x,
    input  logic signed [12:0]  dst_y,
    input  logic [12:0]         rect_width,
    input  logic [12:0]         rect_height,
    input  logic [1:0]          blend_mode,
    input  logic [31:0]         src_pixel,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [1:0]          status,
    output logic [25:0]         fetch_offset,
    output logic [25:0]         store_offset,
    output logic                write_enable,
    output logic [31:0]         write_data,
    output logic                last
);

    crbe_pkg::cfg_t cfg_reg;
    crbe_pkg::job_t push_job, head_job;
    logic push_valid, q_full, q_empty, pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.src_width  <= crbe_pkg::RST_WIDTH;
            cfg_reg.src_pitch  <= crbe_pkg::RST_PITCH;
            cfg_reg.src_height <= crbe_pkg::RST_HEIGHT;
            cfg_reg.dst_width  <= crbe_pkg::RST_WIDTH;
            cfg_reg.dst_pitch  <= crbe_pkg::RST_PITCH;
            cfg_reg.dst_height <= crbe_pkg::RST_HEIGHT;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                crbe_pkg::REG_SRC_WIDTH:  cfg_reg.src_width  <= cfg_data[12:0];
                crbe_pkg::REG_SRC_PITCH:  cfg_reg.src_pitch  <= cfg_data;
                crbe_pkg::REG_SRC_HEIGHT: cfg_reg.src_height <= cfg_data[12:0];
                crbe_pkg::REG_DST_WIDTH:  cfg_reg.dst_width  <= cfg_data[12:0];
                crbe_pkg::REG_DST_PITCH:  cfg_reg.dst_pitch  <= cfg_data;
                crbe_pkg::REG_DST_HEIGHT: cfg_reg.dst_height <= cfg_data[12:0];
                default: ;
            endcase
        end
    end

    crbe_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .src_x       (src_x),
        .src_y       (src_y),
        .dst_x       (dst_x),
        .dst_y       (dst_y),
        .rect_width  (rect_width),
        .rect_height (rect_height),
        .blend_mode  (blend_mode),
        .src_pixel   (src_pixel),
        .push_valid  (push_valid),
        .push_ready  (!q_full),
        .push_job    (push_job)
    );

    crbe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push_valid && !q_full),
        .wdata (push_job),
        .full  (q_full),
        .pop   (pop),
        .rdata (head_job),
        .empty (q_empty)
    );

    crbe_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .job_valid    (!q_empty),
        .job          (head_job),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .fetch_offset (fetch_offset),
        .store_offset (store_offset),
        .write_enable (write_enable),
        .write_data   (write_data),
        .last         (last)
    );

endmodule

[bench/clipped_rect_blit_engine_tb.sv]
`timescale 1ns / 1ps

module clipped_rect_blit_engine_tb;

    localparam logic [1:0] MODE_BAD2 = 2'd2;
    localparam logic [1:0] MODE_BAD3 = 2'd3;

    typedef struct packed {
        logic        op;
        logic [12:0] sx;
        logic [12:0] sy;
        logic [12:0] dx;
        logic [12:0] dy;
        logic [12:0] rw;
        logic [12:0] rh;
        logic [1:0]  mode;
        logic [31:0] pixel;
    } blit_req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [25:0] fetch_ofs;
        logic [25:0] store_ofs;
        logic        we;
        logic [31:0] data;
        logic        last;
    } blit_result_t;

    class blit_scoreboard;
        logic [12:0] src_w, src_h, dst_w, dst_h;
        logic [14:0] src_pitch, dst_pitch;
        bit          running;
        bit          thresh_mode;
        logic [12:0] clip_w, clip_h, col_cnt, row_cnt;
        logic [25:0] src_row, dst_row, src_cur, dst_cur;
        blit_result_t due[$];
        int          errors;
        int          result_no;

        function new();
            src_w = crbe_pkg::RST_WIDTH;
            src_h = crbe_pkg::RST_HEIGHT;
            src_pitch = crbe_pkg::RST_PITCH;
            dst_w = crbe_pkg::RST_WIDTH;
            dst_h = crbe_pkg::RST_HEIGHT;
            dst_pitch = crbe_pkg::RST_PITCH;
            running = 0; thresh_mode = 0;
            clip_w = '0; clip_h = '0; col_cnt = '0; row_cnt = '0;
            src_row = '0; dst_row = '0; src_cur = '0; dst_cur = '0;
            errors = 0; result_no = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [14:0] v);
            case (idx)
                crbe_pkg::REG_SRC_WIDTH:  src_w = v[12:0];
                crbe_pkg::REG_SRC_PITCH:  src_pitch = v;
                crbe_pkg::REG_SRC_HEIGHT: src_h = v[12:0];
                crbe_pkg::REG_DST_WIDTH:  dst_w = v[12:0];
                crbe_pkg::REG_DST_PITCH:  dst_pitch = v;
                crbe_pkg::REG_DST_HEIGHT: dst_h = v[12:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return due.size();
        endfunction

        function void note_request(blit_req_t r);
            blit_result_t e;
            int sx, sy, dx, dy, bw, bh, so, dof;
            bit is_last;
            e = '0;
            is_last = 0;
            if (r.op == crbe_pkg::OP_START)
            begin
                sx = $signed(r.sx); sy = $signed(r.sy);
                dx = $signed(r.dx); dy = $signed(r.dy);
                bw = int'(r.rw); bh = int'(r.rh);
                if (bw > crbe_pkg::MAX_DIM) bw = crbe_pkg::MAX_DIM;
                if (bh > crbe_pkg::MAX_DIM) bh = crbe_pkg::MAX_DIM;
                // top-left clip moves the corners inward
                if (sx < 0)
                begin
                    bw += sx; dx -= sx; sx = 0;
                end
                if (sy < 0)
                begin
                    bh += sy; dy -= sy; sy = 0;
                end
                if (dx < 0)
                begin
                    bw += dx; sx -= dx; dx = 0;
                end
                if (dy < 0)
                begin
                    bh += dy; sy -= dy; dy = 0;
                end
                if (sx + bw - int'(src_w) > 0) bw = int'(src_w) - sx;
                if (sy + bh - int'(src_h) > 0) bh = int'(src_h) - sy;
                if (dx + bw - int'(dst_w) > 0) bw = int'(dst_w) - dx;
                if (dy + bh - int'(dst_h) > 0) bh = int'(dst_h) - dy;
                running = 0;
                if (bw <= 0 || bh <= 0)
                    e.status = crbe_pkg::ST_EMPTY;
                else if (r.mode != crbe_pkg::MODE_DIRECT && r.mode != crbe_pkg::MODE_THRESH)
                    e.status = crbe_pkg::ST_MODE;
                else
                begin
                    so  = sy * int'(src_pitch) + sx * 4;
                    dof = dy * int'(dst_pitch) + dx * 4;
                    running = 1;
                    thresh_mode = (r.mode == crbe_pkg::MODE_THRESH);
                    clip_w = bw[12:0]; clip_h = bh[12:0];
                    col_cnt = '0; row_cnt = '0;
                    src_row = so[25:0]; dst_row = dof[25:0];
                    src_cur = so[25:0]; dst_cur = dof[25:0];
                    e.status = crbe_pkg::ST_OK;
                    e.fetch_ofs = so[25:0];
                    e.store_ofs = dof[25:0];
                end
            end
            else if (!running)
            begin
                e.status = crbe_pkg::ST_IDLE;
            end
            else
            begin
                e.status = crbe_pkg::ST_OK;
                e.we = thresh_mode ? r.pixel[31] : 1'b1;
                e.data = r.pixel;
                e.store_ofs = dst_cur;
                col_cnt = col_cnt + 13'd1;
                if (col_cnt >= clip_w)
                begin
                    col_cnt = '0;
                    row_cnt = row_cnt + 13'd1;
                    src_row = src_row + {11'd0, src_pitch};
                    dst_row = dst_row + {11'd0, dst_pitch};
                    src_cur = src_row;
                    dst_cur = dst_row;
                    is_last = (row_cnt >= clip_h);
                end
                else
                begin
                    src_cur = src_cur + 26'd4;
                    dst_cur = dst_cur + 26'd4;
                end
                e.fetch_ofs = is_last ? '0 : src_cur;
                e.last = is_last;
                if (is_last) running = 0;
            end
            due.push_back(e);
        endfunction

        task report(string msg);
            $display("MISMATCH @%0t: %s", $realtime, msg);
            errors++;
        endtask

        task compare_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report($sformatf("result %0d %s: got %0h, want %0h",
                                 result_no, name, got, want));
        endtask

        task check_result(blit_result_t got);
            blit_result_t want;
            if (due.size() == 0)
            begin
                report($sformatf("result %0d arrived with nothing outstanding", result_no));
            end
            else
            begin
                want = due.pop_front();
                compare_field("status", 32'(got.status), 32'(want.status));
                compare_field("fetch_offset", 32'(got.fetch_ofs), 32'(want.fetch_ofs));
                compare_field("store_offset", 32'(got.store_ofs), 32'(want.store_ofs));
                compare_field("write_enable", 32'(got.we), 32'(want.we));
                compare_field("write_data", got.data, want.data);
                compare_field("last", 32'(got.last), 32'(want.last));
            end
            result_no++;
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_write;
    logic [2:0]  cfg_index;
    logic [14:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic        opcode;
    logic signed [12:0] src_x, src_y, dst_x, dst_y;
    logic [12:0] rect_width, rect_height;
    logic [1:0]  blend_mode;
    logic [31:0] src_pixel;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  status;
    logic [25:0] fetch_offset;
    logic [25:0] store_offset;
    logic        write_enable;
    logic [31:0] write_data;
    logic        last;

    blit_scoreboard sb;
    int send_idle_pct = 21;
    int recv_idle_pct = 60;
    int long_stall_cycles = 0;

    clipped_rect_blit_engine u_dut (.*);

    always #6 clk = ~clk;

    // receiver: random back-pressure, plus an occasional long hold-off
    initial
    begin
        int hold;
        hold = 0;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_stall_cycles > 0)
            begin
                hold = long_stall_cycles;
                long_stall_cycles = 0;
            end
            if (hold > 0)
            begin
                hold--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // outputs sampled mid-cycle, clear of the driving edge
    always @(negedge clk)
    begin
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
            sb.check_result({status, fetch_offset, store_offset, write_enable,
                             write_data, last});
    end

    initial
    begin
        #9_600_000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic blit_req_t mk_start(int sx, int sy, int dx, int dy,
                                           int w, int h, logic [1:0] mode);
        blit_req_t r;
        r.op = crbe_pkg::OP_START;
        r.sx = 13'(sx); r.sy = 13'(sy); r.dx = 13'(dx); r.dy = 13'(dy);
        r.rw = 13'(w); r.rh = 13'(h);
        r.mode = mode;
        r.pixel = $urandom;
        return r;
    endfunction

    function automatic blit_req_t mk_pixel(logic [31:0] pix);
        blit_req_t r;
        r = mk_start($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                     2'($urandom_range(3)));
        r.op = crbe_pkg::OP_PIXEL;
        r.pixel = pix;
        return r;
    endfunction

    function automatic int edge_coord(int extent);
        if ($urandom_range(1)) return int'($urandom_range(8)) - 4;
        return extent - int'($urandom_range(8));
    endfunction

    function automatic int rand_extent();
        if ($urandom_range(99) < 70) return int'($urandom_range(1, 24));
        return int'($urandom_range(1, 4096));
    endfunction

    function automatic int rand_pitch(int w);
        if ($urandom_range(1)) return (w * 4 > 16384) ? 16384 : w * 4;
        return int'($urandom_range(4, 16384));
    endfunction

    function automatic blit_req_t random_start();
        int w, h;
        logic [1:0] mode;
        if ($urandom_range(99) < 15)
            return mk_start($urandom, $urandom, $urandom, $urandom,
                            $urandom_range(8191), $urandom_range(8191),
                            2'($urandom_range(3)));
        w = ($urandom_range(99) < 3) ? 0 : int'($urandom_range(1, 6));
        h = ($urandom_range(99) < 3) ? 0 : int'($urandom_range(1, 6));
        mode = ($urandom_range(99) < 6) ? 2'($urandom_range(2, 3)) : 2'($urandom_range(1));
        return mk_start(edge_coord(sb.src_w), edge_coord(sb.src_h),
                        edge_coord(sb.dst_w), edge_coord(sb.dst_h), w, h, mode);
    endfunction

    task automatic send_request(input blit_req_t r);
        bit taken;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        opcode      <= r.op;
        src_x       <= r.sx;
        src_y       <= r.sy;
        dst_x       <= r.dx;
        dst_y       <= r.dy;
        rect_width  <= r.rw;
        rect_height <= r.rh;
        blend_mode  <= r.mode;
        src_pixel   <= r.pixel;
        do
        begin
            @(negedge clk);
            taken = in_ready;
            @(posedge clk);
        end
        while (!taken);
        sb.note_request(r);
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    task automatic load_surfaces(input int sw, sp, sh, dw, dp, dh);
        logic [2:0]  ids [6];
        logic [14:0] vals [6];
        ids  = '{crbe_pkg::REG_SRC_WIDTH, crbe_pkg::REG_SRC_PITCH, crbe_pkg::REG_SRC_HEIGHT,
                 crbe_pkg::REG_DST_WIDTH, crbe_pkg::REG_DST_PITCH, crbe_pkg::REG_DST_HEIGHT};
        vals = '{15'(sw), 15'(sp), 15'(sh), 15'(dw), 15'(dp), 15'(dh)};
        for (int i = 0; i < 6; i++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= ids[i];
            cfg_data  <= vals[i];
            sb.write_reg(ids[i], vals[i]);
            @(posedge clk);
        end
        cfg_write <= 1'b0;
    endtask

    initial
    begin
        blit_req_t req;
        int issued;
        int sw, sh, dw, dh;
        sb = new();
        issued = 0;
        rst_n = 1'b0;
        cfg_write = 1'b0; cfg_index = '0; cfg_data = '0;
        in_valid = 1'b0; opcode = crbe_pkg::OP_START;
        src_x = '0; src_y = '0; dst_x = '0; dst_y = '0;
        rect_width = '0; rect_height = '0;
        blend_mode = crbe_pkg::MODE_DIRECT; src_pixel = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed requests on the reset-time surfaces
        send_request(mk_pixel(32'hFFFF_FFFF));
        send_request(mk_start(-4096, -4096, -4096, -4096, 8191, 8191, crbe_pkg::MODE_DIRECT));
        send_request(mk_start(4095, 4095, 4095, 4095, 4096, 4096, crbe_pkg::MODE_THRESH));
        send_request(mk_start(0, 0, 0, 0, 0, 5, crbe_pkg::MODE_DIRECT));
        send_request(mk_start(0, 0, 0, 0, 4, 0, MODE_BAD3));   // empty wins over mode
        send_request(mk_start(1, 1, 1, 1, 2, 2, MODE_BAD2));
        send_request(mk_start(1, 1, 1, 1, 2, 2, MODE_BAD3));
        send_request(mk_start(-1, -1, 10, 10, 3, 3, crbe_pkg::MODE_DIRECT));
        send_request(mk_pixel(32'h0000_0000));
        send_request(mk_pixel(32'hFFFF_FFFF));
        send_request(mk_pixel(32'h7FFF_FFFF));
        send_request(mk_pixel(32'h8000_0000));
        send_request(mk_start(638, 478, -1, 0, 4, 3, crbe_pkg::MODE_THRESH));
        send_request(mk_pixel(32'h7FFF_FFFF));
        send_request(mk_pixel(32'h8000_0000));
        send_request(mk_start(0, 0, 0, 0, 8191, 8191, crbe_pkg::MODE_THRESH));
        send_request(mk_pixel(32'h1234_5678));
        send_request(mk_pixel(32'hC0DE_0001));
        // replaces running blit
        send_request(mk_start(5, 5, 3, 3, 1, 1, crbe_pkg::MODE_DIRECT));
        send_request(mk_pixel(32'hA5A5_5A5A));
        send_request(mk_start(0, 0, 0, 0, 4096, 4096, crbe_pkg::MODE_DIRECT));
        send_request(mk_start(4095, 0, 0, 0, 1, 1, crbe_pkg::MODE_DIRECT));
        send_request(mk_pixel(32'h0F0F_F0F0));

        for (int p = 0; p < 10; p++)
        begin
            wait_drain();
            case (p)
                0: load_surfaces(4096, 16384, 4096, 4096, 16384, 4096);
                1: load_surfaces(1, 4, 1, 1, 4, 1);
                2: load_surfaces(8191, 32767, 8191, 8191, 32767, 8191);
                3: load_surfaces(0, 0, rand_extent(), rand_extent(), 4, 0);
                default:
                begin
                    sw = rand_extent(); sh = rand_extent();
                    dw = rand_extent(); dh = rand_extent();
                    load_surfaces(sw, rand_pitch(sw), sh, dw, rand_pitch(dw), dh);
                end
            endcase
            if (p == 2)
            begin
                // row offsets wrap past the 26-bit range
                send_request(mk_start(0, 3000, 0, 3000, 2, 2, crbe_pkg::MODE_DIRECT));
                repeat (4) send_request(mk_pixel($urandom));
            end
            if (p == 4) long_stall_cycles = 300;
            for (int i = 0; i < 100; i++)
            begin
                if (issued < 333)
                begin
                    send_idle_pct = 21; recv_idle_pct = 60;
                end
                else if (issued < 666)
                begin
                    send_idle_pct = 60; recv_idle_pct = 21;
                end
                else
                begin
                    send_idle_pct = 0; recv_idle_pct = 0;
                end
                if ((p == 6 && i == 50) || $urandom_range(199) == 0) wait_drain();
                if (sb.running && $urandom_range(99) < 93) req = mk_pixel($urandom);
                else if (!sb.running && $urandom_range(99) < 6) req = mk_pixel($urandom);
                else req = random_start();
                send_request(req);
                issued++;
            end
        end

        wait_drain();
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

[filelist.f]
design/crbe_pkg.sv
design/crbe_front.sv
design/crbe_queue.sv
design/crbe_back.sv
design/clipped_rect_blit_engine.sv
bench/clipped_rect_blit_engine_tb.sv
